// File: src/mat_pkg.sv
// Shared types and character constants for the macro attribute tokenizer.
`default_nettype none

package mat_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h7B; // '{'
	localparam logic [7:0] CH_COLON = 8'h3A; // ':'
	localparam logic [7:0] CH_EQ    = 8'h3D; // '='
	localparam logic [7:0] CH_BAR   = 8'h7C; // '|'
	localparam logic [7:0] CH_CLOSE = 8'h7D; // '}'
	localparam logic [7:0] CH_QUOTE = 8'h22; // '"'
	localparam logic [7:0] CH_DOT   = 8'h2E; // '.'

	typedef enum logic [2:0] {
		KIND_KEY   = 3'd0,
		KIND_VALUE = 3'd1,
		KIND_DONE  = 3'd2,
		KIND_OK    = 3'd3,
		KIND_ERR   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		PH_OPEN  = 3'd0,
		PH_NAME  = 3'd1,
		PH_KEY   = 3'd2,
		PH_VALUE = 3'd3,
		PH_END   = 3'd4,
		PH_ERROR = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_REPLAY = 2'd1,
		ST_DOT    = 2'd2,
		ST_TAIL   = 2'd3
	} eng_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

endpackage

`default_nettype wire

// File: src/mat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// hold read data until the next read
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/macro_attribute_tokenizer_unit.sv
// Top level of the macro attribute tokenizer.
`default_nettype none

// Takes one byte of a message shaped {name:key=value|key=value} per input
// transaction and returns key bytes, value bytes, pair-done marks and a final
// ok/error status on the output channel, the last result of each input marked
// by run_last. The name is written into a small RAM (NAME_DEPTH bytes) as it
// arrives. One input transaction is worked on at a time: a byte that gives no
// result, or one result while the output register can take it, lets the next
// byte be accepted in the following cycle even while that result still sits in
// the output register; if the register is still full, the result waits until it
// is free and holds the input. The first byte of each attribute additionally
// replays the stored name and a dot through the RAM read port, one byte per
// cycle while the output side takes them, ahead of any result of its own, and
// holds the input meanwhile. Reset needs no clearing pass; the end-of-message
// transaction returns all parse state to its reset value.
module macro_attribute_tokenizer_unit #(
	parameter int NAME_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mat_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mat_pkg::out_item_t      out_item
);

	import mat_pkg::*;

	localparam int AW = (NAME_DEPTH > 1) ? $clog2(NAME_DEPTH) : 1;
	localparam int LW = $clog2(NAME_DEPTH + 1);
	localparam logic [LW-1:0] DEPTH_L = LW'(NAME_DEPTH);

	// parse state
	phase_t      phase_q;
	logic [LW-1:0] len_q;
	logic        pend_q;

	// engine state
	eng_state_t  state_q, state_d;
	logic [LW-1:0] idx_q;
	logic        tail_has_q;
	kind_t       tail_kind_q;
	logic [7:0]  tail_byte_q;

	// output register
	logic        out_valid_q;
	out_item_t   out_item_q;

	// decode of the accepted byte
	phase_t      nxt_phase;
	logic [LW-1:0] nxt_len;
	logic        nxt_pend;
	logic        do_replay;
	logic        has_tail;
	kind_t       tail_kind;
	logic [7:0]  tail_byte;
	logic        wr_en;

	// datapath control
	logic        accept;
	logic        out_free;
	logic        out_load;
	out_item_t   out_next;
	logic        rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]  rd_data;
	logic [LW-1:0] idx_plus;
	logic        replay_more;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign idx_plus    = idx_q + LW'(1);
	assign replay_more = (idx_plus < len_q);

	mat_ram #(
		.WIDTH (8),
		.DEPTH (NAME_DEPTH)
	) u_name_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (len_q[AW-1:0]),
		.wr_data (in_item.data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Work out the parse update and the byte's own result (the tail)
	always_comb begin
		nxt_phase = phase_q;
		nxt_len   = len_q;
		nxt_pend  = pend_q;
		do_replay = 1'b0;
		has_tail  = 1'b0;
		tail_kind = KIND_KEY;
		tail_byte = 8'h00;
		wr_en     = 1'b0;
		if (in_item.end_of_message) begin
			// report status and drop back to the start
			has_tail  = 1'b1;
			tail_kind = (phase_q == PH_END) ? KIND_OK : KIND_ERR;
			nxt_phase = PH_OPEN;
			nxt_len   = '0;
			nxt_pend  = 1'b0;
		end else begin
			case (phase_q)
				PH_OPEN: begin
					if (in_item.data_byte == CH_OPEN) begin
						nxt_phase = PH_NAME;
						nxt_len   = '0;
					end else begin
						nxt_phase = PH_ERROR;
					end
				end
				PH_NAME: begin
					if (in_item.data_byte == CH_COLON) begin
						nxt_phase = PH_KEY;
						nxt_pend  = 1'b1;
					end else if (in_item.data_byte == CH_QUOTE || len_q >= DEPTH_L) begin
						nxt_phase = PH_ERROR;
					end else begin
						wr_en   = accept;
						nxt_len = len_q + LW'(1);
					end
				end
				PH_KEY: begin
					do_replay = pend_q;
					nxt_pend  = 1'b0;
					if (in_item.data_byte == CH_EQ) begin
						nxt_phase = PH_VALUE;
					end else if (in_item.data_byte == CH_BAR) begin
						has_tail  = 1'b1;
						tail_kind = KIND_DONE;
						nxt_pend  = 1'b1;
					end else if (in_item.data_byte == CH_CLOSE) begin
						has_tail  = 1'b1;
						tail_kind = KIND_DONE;
						nxt_phase = PH_END;
					end else begin
						has_tail  = 1'b1;
						tail_kind = KIND_KEY;
						tail_byte = in_item.data_byte;
					end
				end
				PH_VALUE: begin
					if (in_item.data_byte == CH_BAR) begin
						has_tail  = 1'b1;
						tail_kind = KIND_DONE;
						nxt_phase = PH_KEY;
						nxt_pend  = 1'b1;
					end else if (in_item.data_byte == CH_CLOSE) begin
						has_tail  = 1'b1;
						tail_kind = KIND_DONE;
						nxt_phase = PH_END;
					end else begin
						has_tail  = 1'b1;
						tail_kind = KIND_VALUE;
						tail_byte = in_item.data_byte;
					end
				end
				default: begin
					nxt_phase = PH_ERROR;
				end
			endcase
		end
	end

	// Next engine state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (do_replay) begin
						state_d = (len_q == '0) ? ST_DOT : ST_REPLAY;
					end else if (has_tail && !out_free) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_REPLAY: begin
				if (out_free && !replay_more) begin
					state_d = ST_DOT;
				end
			end
			ST_DOT: begin
				if (out_free) begin
					state_d = tail_has_q ? ST_TAIL : ST_IDLE;
				end
			end
			ST_TAIL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register loads and name RAM reads
	always_comb begin
		out_load = 1'b0;
		out_next = '{kind: KIND_KEY, out_byte: 8'h00, run_last: 1'b0};
		rd_en    = 1'b0;
		rd_addr  = idx_plus[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && do_replay) begin
					// prime the first name byte
					rd_en   = (len_q != '0);
					rd_addr = '0;
				end else if (accept && has_tail && out_free) begin
					out_load = 1'b1;
					out_next = '{kind: tail_kind, out_byte: tail_byte, run_last: 1'b1};
				end
			end
			ST_REPLAY: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{kind: KIND_KEY, out_byte: rd_data, run_last: 1'b0};
					rd_en    = replay_more;
				end
			end
			ST_DOT: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{kind: KIND_KEY, out_byte: CH_DOT, run_last: !tail_has_q};
				end
			end
			ST_TAIL: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next = '{kind: tail_kind_q, out_byte: tail_byte_q, run_last: 1'b1};
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_OPEN;
			len_q       <= '0;
			pend_q      <= 1'b0;
			idx_q       <= '0;
			tail_has_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				phase_q    <= nxt_phase;
				len_q      <= nxt_len;
				pend_q     <= nxt_pend;
				tail_has_q <= has_tail;
				idx_q      <= '0;
			end else if (state_q == ST_REPLAY && out_free && replay_more) begin
				// advance to the next name byte
				idx_q <= idx_plus;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold the tail result and the output transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			tail_kind_q <= tail_kind;
			tail_byte_q <= tail_byte;
		end
		if (out_load) begin
			out_item_q <= out_next;
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_macro_attribute_tokenizer_unit.sv
// Self-checking testbench for the macro attribute tokenizer top level.

module tb_macro_attribute_tokenizer_unit;

	import mat_pkg::*;

	localparam int NAME_DEPTH   = 32;
	localparam int RANDOM_ITEMS = 190;
	localparam int IDLE_PCT     = 26;
	localparam int STALL_LIMIT  = 1000; // cycles with no transaction on either side
	localparam int TAIL_CYCLES  = 2 * NAME_DEPTH + 8;

	// One row of the directed table. Where typed is set, the row carries its own
	// expectation: nothing at all, or a single status/none result.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
		logic       typed;
		logic       has_result;
		kind_t      kind;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// Predictor state: a private copy of the parser.
	phase_t     parse_phase;
	logic [7:0] name_bytes [NAME_DEPTH];
	int         name_len;
	logic       attr_pending;

	out_item_t  step_results[$];   // results of the byte just accepted
	out_item_t  pending_tokens[$]; // results still to come from the block
	in_item_t   msg_bytes[$];      // random message under construction

	stim_row_t  directed_rows [23];
	int         mismatches = 0;
	int         random_items;
	int         idle_cycles = 0;
	logic       calm;

	macro_attribute_tokenizer_unit #(
		.NAME_DEPTH(NAME_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void add_token(input kind_t kind, input logic [7:0] value);
		out_item_t tok;
		tok.kind     = kind;
		tok.out_byte = value;
		tok.run_last = 1'b0;
		step_results.push_back(tok);
	endfunction

	// Work out what one accepted transaction produces and advance the parser copy.
	function automatic void tokenize_byte(input in_item_t it);
		int i;
		logic [7:0] c;
		c = it.data_byte;
		step_results.delete();
		if (it.end_of_message) begin
			// Status only: ok solely when the closing brace was the last byte.
			if (parse_phase == PH_END) begin
				add_token(KIND_OK, 8'h00);
			end else begin
				add_token(KIND_ERR, 8'h00);
			end
			parse_phase  = PH_OPEN;
			name_len     = 0;
			attr_pending = 1'b0;
		end else begin
			case (parse_phase)
				PH_OPEN: begin
					if (c == CH_OPEN) begin
						parse_phase = PH_NAME;
						name_len    = 0;
					end else begin
						parse_phase = PH_ERROR;
					end
				end
				PH_NAME: begin
					if (c == CH_COLON) begin
						parse_phase  = PH_KEY;
						attr_pending = 1'b1;
					end else if (c == CH_QUOTE || name_len >= NAME_DEPTH) begin
						parse_phase = PH_ERROR;
					end else begin
						name_bytes[name_len] = c;
						name_len++;
					end
				end
				PH_KEY: begin
					// First byte of an attribute: replay the name and a dot ahead of it.
					if (attr_pending) begin
						for (i = 0; i < name_len; i++) begin
							add_token(KIND_KEY, name_bytes[i]);
						end
						add_token(KIND_KEY, CH_DOT);
						attr_pending = 1'b0;
					end
					if (c == CH_EQ) begin
						parse_phase = PH_VALUE;
					end else if (c == CH_BAR) begin
						add_token(KIND_DONE, 8'h00);
						attr_pending = 1'b1;
					end else if (c == CH_CLOSE) begin
						add_token(KIND_DONE, 8'h00);
						parse_phase = PH_END;
					end else begin
						add_token(KIND_KEY, c);
					end
				end
				PH_VALUE: begin
					// An equals sign here is plain value text.
					if (c == CH_BAR) begin
						add_token(KIND_DONE, 8'h00);
						parse_phase  = PH_KEY;
						attr_pending = 1'b1;
					end else if (c == CH_CLOSE) begin
						add_token(KIND_DONE, 8'h00);
						parse_phase = PH_END;
					end else begin
						add_token(KIND_VALUE, c);
					end
				end
				default: begin
					// Anything after the closing brace, and anything in error, stays in error.
					parse_phase = PH_ERROR;
				end
			endcase
		end
		if (step_results.size() > 0) begin
			step_results[step_results.size() - 1].run_last = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one transaction, hold it until taken, then record what it should cause.
	// A typed row replaces the predicted results with its own expectation.
	task automatic send_item(input in_item_t it, input logic typed, input logic has_result,
			input kind_t kind);
		out_item_t tok;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do begin
			@(posedge clk);
		end while (!in_ready);
		random_items++;
		tokenize_byte(it);
		if (typed) begin
			if (has_result) begin
				tok.kind     = kind;
				tok.out_byte = 8'h00;
				tok.run_last = 1'b1;
				pending_tokens.push_back(tok);
			end
		end else begin
			foreach (step_results[j]) begin
				pending_tokens.push_back(step_results[j]);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Random message construction
	// ------------------------------------------------------------------

	function automatic void put_byte(input logic [7:0] value);
		in_item_t it;
		it.data_byte      = value;
		it.end_of_message = 1'b0;
		msg_bytes.push_back(it);
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(6))
			0:       return CH_OPEN;
			1:       return CH_COLON;
			2:       return CH_EQ;
			3:       return CH_BAR;
			4:       return CH_CLOSE;
			5:       return CH_QUOTE;
			default: return CH_DOT;
		endcase
	endfunction

	// Mostly well-formed messages with random text; the rest broken or pure noise.
	function automatic void build_message();
		int n_name;
		int n_attr;
		int a;
		int k;
		int pick;
		logic [7:0] b;
		msg_bytes.delete();
		put_byte(CH_OPEN);
		pick = $urandom_range(99);
		if (pick < 6) begin
			n_name = NAME_DEPTH;       // full store, longest replay
		end else if (pick < 10) begin
			n_name = NAME_DEPTH + 1;   // one byte too many
		end else begin
			n_name = $urandom_range(5);
		end
		for (k = 0; k < n_name; k++) begin
			do begin
				b = 8'($urandom_range(255));
			end while (b == CH_COLON || b == CH_QUOTE);
			put_byte(b);
		end
		put_byte(CH_COLON);
		n_attr = $urandom_range(1, 4);
		for (a = 0; a < n_attr; a++) begin
			for (k = $urandom_range(3); k > 0; k--) begin
				do begin
					b = 8'($urandom_range(255));
				end while (b == CH_EQ || b == CH_BAR || b == CH_CLOSE);
				put_byte(b);
			end
			if ($urandom_range(9) < 7) begin
				put_byte(CH_EQ);
				for (k = $urandom_range(4); k > 0; k--) begin
					do begin
						b = 8'($urandom_range(255));
					end while (b == CH_BAR || b == CH_CLOSE);
					put_byte(b);
				end
			end
			put_byte((a == n_attr - 1) ? CH_CLOSE : CH_BAR);
		end

		// Break a share of them.
		pick = $urandom_range(99);
		if (pick < 8) begin
			// cut short
			for (k = $urandom_range(msg_bytes.size()); k > 0; k--) begin
				void'(msg_bytes.pop_back());
			end
		end else if (pick < 15) begin
			// stray byte somewhere
			b = ($urandom_range(1)) ? pick_special() : 8'($urandom_range(255));
			msg_bytes.insert($urandom_range(msg_bytes.size()), '{b, 1'b0});
		end else if (pick < 21) begin
			// trailing byte after the closing brace
			put_byte(8'($urandom_range(255)));
		end else if (pick < 27) begin
			// noise, usually without an opening brace
			msg_bytes.delete();
			for (k = $urandom_range(6); k > 0; k--) begin
				put_byte(($urandom_range(3) == 0) ? pick_special() : 8'($urandom_range(255)));
			end
		end else if (pick < 32) begin
			// overwrite one byte with a delimiter
			msg_bytes[$urandom_range(msg_bytes.size() - 1)].data_byte = pick_special();
		end
	endfunction

	// ------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic note_mismatch(input logic unexpected, input out_item_t want,
			input out_item_t got);
		mismatches++;
		if (mismatches <= 10) begin
			if (unexpected) begin
				$display("unexpected result: kind %0d byte %02h last %0d",
					got.kind, got.out_byte, got.run_last);
			end else begin
				$display("mismatch: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
					want.kind, want.out_byte, want.run_last,
					got.kind, got.out_byte, got.run_last);
			end
		end
	endtask

	// Compare each accepted result against the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				note_mismatch(1'b1, out_item, out_item);
			end else begin
				want = pending_tokens.pop_front();
				if (out_item.kind !== want.kind || out_item.out_byte !== want.out_byte
						|| out_item.run_last !== want.run_last) begin
					note_mismatch(1'b0, want, out_item);
				end
			end
		end
	end

	// Watchdog: end the run if neither side moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		in_item_t it;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_item      = '0;
		calm         = 1'b0;
		random_items = 0;
		parse_phase  = PH_OPEN;
		name_len     = 0;
		attr_pending = 1'b0;
		foreach (name_bytes[r]) begin
			name_bytes[r] = 8'h00;
		end

		directed_rows = '{
			'{8'hFF,    1'b1, 1'b1, 1'b1, KIND_ERR}, // empty message straight after reset
			'{8'h78,    1'b0, 1'b1, 1'b0, KIND_KEY}, // missing opening brace
			'{8'h00,    1'b1, 1'b1, 1'b1, KIND_ERR},
			'{CH_OPEN,  1'b0, 1'b1, 1'b0, KIND_KEY},
			'{8'h6E,    1'b0, 1'b1, 1'b0, KIND_KEY},
			'{CH_QUOTE, 1'b0, 1'b1, 1'b0, KIND_KEY}, // quote in the name
			'{8'h00,    1'b1, 1'b1, 1'b1, KIND_ERR},
			'{CH_OPEN,  1'b0, 1'b1, 1'b0, KIND_KEY},
			'{CH_COLON, 1'b0, 1'b1, 1'b0, KIND_KEY}, // empty name
			'{CH_EQ,    1'b0, 1'b0, 1'b0, KIND_KEY}, // replay ahead of an empty key
			'{8'h00,    1'b0, 1'b0, 1'b0, KIND_KEY},
			'{CH_EQ,    1'b0, 1'b0, 1'b0, KIND_KEY}, // equals inside a value
			'{CH_BAR,   1'b0, 1'b0, 1'b0, KIND_KEY},
			'{CH_BAR,   1'b0, 1'b0, 1'b0, KIND_KEY}, // replay then pair done
			'{CH_CLOSE, 1'b0, 1'b0, 1'b0, KIND_KEY}, // replay then closing pair done
			'{8'hFF,    1'b0, 1'b1, 1'b0, KIND_KEY}, // byte after the closing brace
			'{8'h00,    1'b1, 1'b1, 1'b1, KIND_ERR},
			'{CH_OPEN,  1'b0, 1'b1, 1'b0, KIND_KEY},
			'{8'h61,    1'b0, 1'b1, 1'b0, KIND_KEY},
			'{CH_COLON, 1'b0, 1'b1, 1'b0, KIND_KEY},
			'{8'h6B,    1'b0, 1'b0, 1'b0, KIND_KEY},
			'{CH_CLOSE, 1'b0, 1'b0, 1'b0, KIND_KEY},
			'{8'h00,    1'b1, 1'b1, 1'b1, KIND_OK}   // clean message
		};

		// Hold reset, then release it once.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			it.data_byte      = directed_rows[r].data_byte;
			it.end_of_message = directed_rows[r].end_of_message;
			send_item(it, directed_rows[r].typed, directed_rows[r].has_result,
				directed_rows[r].kind);
		end

		// Random messages, each closed by an end marker. A middle stretch runs
		// with neither side idling.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			calm = (random_items >= 80 && random_items < 140);
			build_message();
			foreach (msg_bytes[r]) begin
				send_item(msg_bytes[r], 1'b0, 1'b0, KIND_KEY);
			end
			it.data_byte      = 8'($urandom_range(255));
			it.end_of_message = 1'b1;
			send_item(it, 1'b0, 1'b0, KIND_KEY);
		end
		in_valid <= 1'b0;

		// Drain, then give the block time to show any stray result.
		while (pending_tokens.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_tokens.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/mat_pkg.sv
src/mat_ram.sv
src/macro_attribute_tokenizer_unit.sv
tb/sv/tb_macro_attribute_tokenizer_unit.sv
